// File: rtl/mau_pkg.sv
`default_nettype none
package mau_pkg;
   localparam int unsigned VALUE_WIDTH = 64;
   localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam logic [63:0] MOD_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_POW = 3'd3;
   localparam logic [2:0] CMD_INV = 3'd4;
   localparam logic [2:0] CMD_DIV = 3'd5;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // Modular add of two residues below m.
   function automatic value_type add_mod(value_type x, value_type y, value_type m);
      logic [VALUE_WIDTH:0] s;
      logic [VALUE_WIDTH:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, m};
      add_mod = d[VALUE_WIDTH] ? s[VALUE_WIDTH-1:0] : d[VALUE_WIDTH-1:0];
   endfunction

   typedef struct packed {
      logic      start;
      value_type x;
      value_type y;
   } mul_req_type;
endpackage
`default_nettype wire

// File: rtl/mau_mul.sv
`default_nettype none
// Shift-and-add modular multiplier: one bit of y per cycle, most significant first.
module mau_mul
   import mau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   input  wire value_type   modulus,
   output logic             done,
   output value_type        product
);
   logic                 busy_ff, busy_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   value_type            acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic                 done_ff, done_in;
   value_type            dbl, sum;

   always_comb begin
      dbl = add_mod(acc_ff, acc_ff, modulus);
      sum = add_mod(dbl, x_ff, modulus);
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      y_in = y_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH - 1);
         acc_in = '0;
         x_in = req.x;
         y_in = req.y;
      end else if (busy_ff) begin
         acc_in = y_ff[VALUE_WIDTH-1] ? sum : dbl;
         y_in = y_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// File: rtl/mau_div.sv
`default_nettype none
// Restoring divider: one quotient bit per cycle.
module mau_div
   import mau_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire value_type dividend,
   input  wire value_type divisor,
   output logic           done,
   output value_type      quotient,
   output value_type      remainder
);
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   value_type            q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [VALUE_WIDTH:0] sh, df;

   always_comb begin
      sh = {r_ff, q_ff[VALUE_WIDTH-1]};
      df = sh - {1'b0, d_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH - 1);
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
      end else if (busy_ff) begin
         if (!df[VALUE_WIDTH]) begin
            r_in = df[VALUE_WIDTH-1:0];
            q_in = {q_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            r_in = sh[VALUE_WIDTH-1:0];
            q_in = {q_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

// File: rtl/modular_arithmetic_unit.sv
// Every command first reduces both operands modulo m with the divider; an inverse then
// runs Euclid steps (a division, a quotient reduction and a multiply each), and each
// power bit takes a square, with a multiply before it for a set exponent bit.
// One request at a time; req_tready is high only when the sequencer is idle and
// no response is pending. The divider and the multiplier each retire one bit a cycle.
// Synchronous active-high reset returns to idle and loads the modulus reset value.
`default_nettype none
module modular_arithmetic_unit
   import mau_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // command[2:0], operand_a[66:3], operand_b[130:67], exponent[194:131], zero fill
   input  wire logic [199:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result[63:0]
   output logic [63:0]       rsp_tdata,
   // not_invertible
   output logic              rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [63:0]  csr_data
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_RA = 5'd1,  S_RAW = 5'd2, S_RB = 5'd3,
                          S_RBW = 5'd4,  S_DISP = 5'd5, S_MULW = 5'd6, S_PSTEP = 5'd7,
                          S_PMW = 5'd8,  S_PSQ = 5'd9,  S_PSQW = 5'd10, S_IINIT = 5'd11,
                          S_IDIV = 5'd12, S_IDW = 5'd13, S_IQM = 5'd14, S_IQMW = 5'd15,
                          S_IMUL = 5'd16, S_IMW = 5'd17, S_IEND = 5'd18, S_DMUL = 5'd19,
                          S_DMW = 5'd20, S_OUT = 5'd21;

   logic [4:0]  st_ff, st_in;
   logic [63:0] modreg_ff, modreg_in;
   logic [2:0]  cmd_ff, cmd_in;
   value_type   a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [63:0] e_ff, e_in;
   logic        neg_ff, neg_in, err_ff, err_in;
   value_type   r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in, q_ff, q_in;
   logic        ovalid_ff, ovalid_in;
   logic [63:0] odata_ff, odata_in;
   logic        oerr_ff, oerr_in;

   value_type   m_raw, m_eff, one_m;
   mul_req_type mreq;
   logic        mdone, dstart, ddone;
   value_type   mprod, dnum, dden, dquo, drem;

   assign m_raw = modreg_ff[VALUE_WIDTH-1:0];
   assign m_eff = (m_raw < value_type'(2)) ? value_type'(1) : m_raw;
   assign one_m = (m_eff == value_type'(1)) ? '0 : value_type'(1);

   mau_mul u_mul (
      .clock(clock), .reset(reset), .req(mreq), .modulus(m_eff),
      .done(mdone), .product(mprod)
   );
   mau_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum), .divisor(dden),
      .done(ddone), .quotient(dquo), .remainder(drem)
   );

   assign req_tready = (st_ff == S_IDLE) && !ovalid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      st_in = st_ff;
      modreg_in = csr_valid ? csr_data : modreg_ff;
      cmd_in = cmd_ff; a_in = a_ff; b_in = b_ff; e_in = e_ff; res_in = res_ff;
      neg_in = neg_ff; err_in = err_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff; q_in = q_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff; oerr_in = oerr_ff;
      mreq = '0;
      dstart = 1'b0;
      dnum = a_ff;
      dden = m_eff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[2:0];
               a_in = req_tdata[3 +: VALUE_WIDTH];
               b_in = req_tdata[67 +: VALUE_WIDTH];
               e_in = req_tdata[194:131];
               err_in = 1'b0;
               res_in = '0;
               st_in = S_RA;
            end
         end
         S_RA: begin
            dstart = 1'b1; dnum = a_ff; st_in = S_RAW;
         end
         S_RAW: if (ddone) begin
            a_in = drem; st_in = S_RB;
         end
         S_RB: begin
            dstart = 1'b1; dnum = b_ff; st_in = S_RBW;
         end
         S_RBW: if (ddone) begin
            b_in = drem; st_in = S_DISP;
         end
         S_DISP: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  res_in = add_mod(a_ff, b_ff, m_eff); st_in = S_OUT;
               end
               CMD_SUB: begin
                  res_in = (a_ff >= b_ff) ? a_ff - b_ff : m_eff - (b_ff - a_ff);
                  st_in = S_OUT;
               end
               CMD_MUL: begin
                  mreq = '{start: 1'b1, x: a_ff, y: b_ff}; st_in = S_MULW;
               end
               CMD_POW: begin
                  neg_in = e_ff[63];
                  e_in = e_ff[63] ? (~e_ff) + 64'd1 : e_ff;
                  res_in = one_m;
                  st_in = S_PSTEP;
               end
               CMD_INV: begin
                  r1_in = a_ff; st_in = S_IINIT;
               end
               CMD_DIV: begin
                  r1_in = b_ff; st_in = S_IINIT;
               end
               default: begin
                  res_in = '0; st_in = S_OUT;
               end
            endcase
         end
         S_MULW: if (mdone) begin
            res_in = mprod; st_in = S_OUT;
         end
         S_PSTEP: begin
            if (e_ff == '0) begin
               if (neg_ff) begin
                  r1_in = res_ff; st_in = S_IINIT;
               end else begin
                  st_in = S_OUT;
               end
            end else if (e_ff[0]) begin
               mreq = '{start: 1'b1, x: res_ff, y: a_ff}; st_in = S_PMW;
            end else begin
               st_in = S_PSQ;
            end
         end
         S_PMW: if (mdone) begin
            res_in = mprod; st_in = S_PSQ;
         end
         S_PSQ: begin
            mreq = '{start: 1'b1, x: a_ff, y: a_ff}; st_in = S_PSQW;
         end
         S_PSQW: if (mdone) begin
            a_in = mprod; e_in = e_ff >> 1; st_in = S_PSTEP;
         end
         S_IINIT: begin
            r0_in = m_eff; t0_in = '0; t1_in = one_m; st_in = S_IDIV;
         end
         S_IDIV: begin
            if (r1_ff == '0) begin
               st_in = S_IEND;
            end else begin
               dstart = 1'b1; dnum = r0_ff; dden = r1_ff; st_in = S_IDW;
            end
         end
         S_IDW: if (ddone) begin
            q_in = dquo; r0_in = r1_ff; r1_in = drem; st_in = S_IQM;
         end
         // The quotient must be reduced before it enters the modular multiplier.
         S_IQM: begin
            dstart = 1'b1; dnum = q_ff; dden = m_eff; st_in = S_IQMW;
         end
         S_IQMW: if (ddone) begin
            q_in = drem; st_in = S_IMUL;
         end
         S_IMUL: begin
            mreq = '{start: 1'b1, x: q_ff, y: t1_ff}; st_in = S_IMW;
         end
         S_IMW: if (mdone) begin
            t0_in = t1_ff;
            t1_in = (t0_ff >= mprod) ? t0_ff - mprod : m_eff - (mprod - t0_ff);
            st_in = S_IDIV;
         end
         S_IEND: begin
            if (r0_ff != value_type'(1)) begin
               err_in = 1'b1; res_in = '0; st_in = S_OUT;
            end else if (cmd_ff == CMD_DIV) begin
               st_in = S_DMUL;
            end else begin
               res_in = t0_ff; st_in = S_OUT;
            end
         end
         S_DMUL: begin
            mreq = '{start: 1'b1, x: a_ff, y: t0_ff}; st_in = S_DMW;
         end
         S_DMW: if (mdone) begin
            res_in = mprod; st_in = S_OUT;
         end
         S_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               odata_in = 64'(res_ff);
               oerr_in = err_ff;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         modreg_ff <= MOD_RESET;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         modreg_ff <= modreg_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; e_ff <= e_in; res_ff <= res_in;
      neg_ff <= neg_in; err_ff <= err_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in; q_ff <= q_in;
      odata_ff <= odata_in; oerr_ff <= oerr_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tuser = oerr_ff;
endmodule
`default_nettype wire

// File: rtl/mau_checker.sv
`default_nettype none
module mau_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic         rsp_tuser
);
   // An erroneous response always carries a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("error response with non-zero result");
   // No new request while a response waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while response pending");
   // An accepted request cannot be answered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response too early");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
   import mau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT = 100000;

   typedef struct {
      logic [63:0] result;
      logic        not_invertible;
   } residue_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [199:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [63:0]  csr_data;

   residue_type  pending_residues[$];
   logic [63:0]  modulus_shadow;
   int unsigned  error_count;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  recv_hold;
   int unsigned  quiet_cycles;

   modular_arithmetic_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Modular helpers on residues already below m.
   function automatic logic [63:0] mod_sub(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (x >= y) ? x - y : m - (y - x);
   endfunction

   function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic logic mod_inverse(logic [63:0] x, logic [63:0] m,
                                        output logic [63:0] inv);
      logic [63:0] r0, r1, r2, t0, t1, t2, q;
      r0 = m;
      r1 = x;
      t0 = 64'd0;
      t1 = 64'd1 % m;
      while (r1 != 64'd0) begin
         q = r0 / r1;
         r2 = r0 - q * r1;
         t2 = mod_sub(t0, mod_mul(q % m, t1, m), m);
         r0 = r1;
         r1 = r2;
         t0 = t1;
         t1 = t2;
      end
      inv = (r0 == 64'd1) ? t0 : 64'd0;
      return r0 == 64'd1;
   endfunction

   function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e,
                                             logic [63:0] m);
      logic [63:0] r;
      r = 64'd1 % m;
      while (e != 64'd0) begin
         if (e[0]) r = mod_mul(r, base, m);
         base = mod_mul(base, base, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic residue_type predict_residue(logic [2:0] cmd, logic [63:0] a_in,
                                                   logic [63:0] b_in, logic [63:0] e);
      residue_type r;
      logic [63:0] m, a, b, t;
      logic [64:0] s;
      m = (modulus_shadow < 64'd2) ? 64'd1 : modulus_shadow;
      a = a_in % m;
      b = b_in % m;
      r.result = 64'd0;
      r.not_invertible = 1'b0;
      case (cmd)
         CMD_ADD: begin
            s = {1'b0, a} + {1'b0, b};
            r.result = 64'((s >= {1'b0, m}) ? s - {1'b0, m} : s);
         end
         CMD_SUB: r.result = mod_sub(a, b, m);
         CMD_MUL: r.result = mod_mul(a, b, m);
         CMD_POW: begin
            if (e[63]) begin
               r.not_invertible = !mod_inverse(mod_power(a, ~e + 64'd1, m), m, t);
               r.result = t;
            end else begin
               r.result = mod_power(a, e, m);
            end
         end
         CMD_INV: begin
            r.not_invertible = !mod_inverse(a, m, t);
            r.result = t;
         end
         CMD_DIV: begin
            r.not_invertible = !mod_inverse(b, m, t);
            r.result = r.not_invertible ? 64'd0 : mod_mul(a, t, m);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Response checker.
   always @(posedge clock) begin
      residue_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_residues.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 64'd0);
         end else begin
            want = pending_residues.pop_front();
            if (rsp_tdata !== want.result)
               report_mismatch("result", rsp_tdata, want.result);
            if (rsp_tuser !== want.not_invertible)
               report_mismatch("not_invertible", 64'(rsp_tuser), 64'(want.not_invertible));
         end
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_tready <= 1'b0;
         recv_hold--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(logic [2:0] cmd, logic [63:0] a, logic [63:0] b,
                               logic [63:0] e);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tdata  <= {5'd0, e, b, a, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_residues.push_back(predict_residue(cmd, a, b, e));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_modulus(logic [63:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      modulus_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      write_modulus(64'd1000);
      send_request(CMD_ADD, 64'd999, 64'd999, 64'd0);
      send_request(CMD_SUB, 64'd0, 64'd999, 64'd0);
      send_request(CMD_MUL, 64'd999, 64'd999, 64'd0);
      send_request(CMD_POW, 64'd7, 64'd0, 64'd0);
      send_request(CMD_POW, 64'd2, 64'd0, -64'sd1);
      send_request(CMD_POW, 64'd3, 64'd0, 64'h8000_0000_0000_0000);
      send_request(CMD_INV, 64'd3, 64'd0, 64'd0);
      send_request(CMD_INV, 64'd10, 64'd0, 64'd0);
      send_request(CMD_DIV, 64'd7, 64'd3, 64'd0);
      send_request(CMD_DIV, 64'd7, 64'd4, 64'd0);
      send_request(3'd6, 64'd5, 64'd5, 64'd5);
      send_request(3'd7, 64'd5, 64'd5, 64'd5);
      send_request(CMD_ADD, '1, '1, '1);
      drain_responses();
      write_modulus('1);
      send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
      send_request(CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFD, 64'd0);
      send_request(CMD_POW, 64'd2, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(CMD_POW, 64'd2, 64'd0, 64'h8000_0000_0000_0001);
      send_request(CMD_INV, 64'd2, 64'd0, 64'd0);
      send_request(CMD_DIV, 64'd1, 64'd3, 64'd0);
      drain_responses();
      // A modulus below two behaves as a modulus of one.
      write_modulus(64'd0);
      send_request(CMD_INV, 64'd5, 64'd0, 64'd0);
      send_request(CMD_POW, 64'd5, 64'd0, 64'd0);
      drain_responses();
      write_modulus(64'd2);
      send_request(CMD_SUB, 64'd0, 64'd1, 64'd0);
      send_request(CMD_INV, 64'd0, 64'd0, 64'd0);
      drain_responses();
   endtask

   task automatic test_random(int unsigned count, logic [63:0] modulus_value);
      logic [2:0]  cmd;
      logic [63:0] a, b, e;
      write_modulus(modulus_value);
      repeat (count) begin
         cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
         if ($urandom_range(3) != 0) begin
            a = a % modulus_value;
            b = b % modulus_value;
         end
         case ($urandom_range(7))
            0: a = 64'd0;
            1: b = modulus_value - 64'd1;
            default: ;
         endcase
         e = ($urandom_range(4) == 0) ? {$urandom, $urandom}
                                      : 64'($signed(12'($urandom)));
         send_request(cmd, a, b, e);
      end
      drain_responses();
   endtask

   // The receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      recv_hold = 400;
      repeat (4) send_request(CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
      drain_responses();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      modulus_shadow = MOD_RESET;
      error_count = 0;
      quiet_cycles = 0;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      send_idle_pct = 36;
      recv_idle_pct = 57;
      test_random(25, MOD_RESET);
      send_idle_pct = 57;
      recv_idle_pct = 36;
      test_random(25, {$urandom, $urandom} | 64'h8000_0000_0000_0001);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(25, 64'($urandom_range(1000, 2)));
      test_backpressure();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
